>>> rtl/pwn_pkg.sv
// shared constants, item types and mode codes for the winding-number tester
// no dependencies; imported by the top level and by the cell
`timescale 1ns / 1ps

package pwn_pkg;

    // polygon capacity and coordinate width
    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 16;

    // derived widths
    localparam int IDX_W   = $clog2(MAX_VERTICES);
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int WN_W    = $clog2(MAX_VERTICES) + 1;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    // result winding field
    localparam int WIND_W     = 9;
    localparam int WIND_LIMIT = 255;

    // mode codes of the input word
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // what an item does on its way down the chain
    typedef enum logic [1:0] {
        K_NONE,
        K_APPEND,
        K_QUERY
    } t_kind;

    // item handed from cell to cell
    typedef struct packed {
        t_kind                          kind;
        logic signed [COORD_BITS-1:0]   x;
        logic signed [COORD_BITS-1:0]   y;
        logic        [CNT_W-1:0]        cnt;   // target slot of an append, length for a query
        logic                           ovf;
        logic signed [COORD_BITS-1:0]   px;    // vertex of the previous cell
        logic signed [COORD_BITS-1:0]   py;
        logic signed [WN_W-1:0]         wn;    // running winding sum
    } t_item;

endpackage

>>> rtl/polygon_winding_number_test.sv
// top level of the winding-number point-in-polygon tester
// depends on pwn_pkg and pwn_cell
`timescale 1ns / 1ps

// Usage
//   Input channel: i_valid, o_stall, i_mode, i_coord_x, i_coord_y. Mode 0 appends a
//   vertex, mode 1 queries a point, mode 2 clears the polygon; mode 3 is ignored.
//   Output channel: o_valid, i_stall, o_inside_res, o_winding, o_overflowed; one
//   word per query, none for appends, clears or mode 3.
//   The polygon is not closed implicitly: repeat the first vertex at the end.
//   Structure: a row of MAX_VERTICES cells, cell k holding vertex k. Every word
//   walks down the row one cell per cycle while the row moves; an append is stored
//   by the cell of its slot, a query scores the edge ending at each cell k with 0 < k < length.
//   Throughput: one word per cycle while no result is held up, queries and appends mixed freely.
//   Path: a query passes through the cell row and then the output register, the
//   first cell capturing at the accepting edge itself.
//   Reset: vertex count and overflow flag clear, the row empties, no output.
//   Stall: while a result waits under i_stall the whole row holds and o_stall
//   is raised; the row moves again the cycle the result is taken.

module polygon_winding_number_test import pwn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_mode,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_inside_res,
    output logic signed [8:0] o_winding,
    output logic              o_overflowed
);

    logic                     r_out_valid;
    logic                     r_inside;
    logic signed [WIND_W-1:0] r_winding;
    logic                     r_ovf_out;
    logic [CNT_W-1:0]         r_count;
    logic                     r_ovf;
    logic [CNT_W-1:0]         n_count;
    logic                     n_ovf;

    logic                     w_en;
    logic                     w_accept;
    logic                     w_full;
    t_item                    w_head;
    t_item                    w_chain [MAX_VERTICES+1];
    t_item                    w_last;
    logic signed [31:0]       w_wn_ext;
    logic signed [WIND_W-1:0] w_wn_sat;

    // row moves unless a result is held up
    assign w_en     = !(r_out_valid && i_stall);
    assign o_stall  = !w_en;
    assign w_accept = i_valid && w_en;
    assign w_full   = (r_count == CNT_W'(MAX_VERTICES));

    // head: snapshot of polygon length for each word, count and flag update
    always_comb begin
        w_head.kind = K_NONE;
        w_head.x    = i_coord_x[COORD_BITS-1:0];
        w_head.y    = i_coord_y[COORD_BITS-1:0];
        w_head.cnt  = r_count;
        w_head.ovf  = r_ovf;
        w_head.px   = '0;
        w_head.py   = '0;
        w_head.wn   = '0;
        n_count     = r_count;
        n_ovf       = r_ovf;
        if (w_accept) begin
            unique case (i_mode)
                MODE_APPEND: begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_head.kind = K_APPEND;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                MODE_QUERY: begin
                    w_head.kind = K_QUERY;
                end
                MODE_CLEAR: begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
                default: begin
                    w_head.kind = K_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // row of vertex cells
    assign w_chain[0] = w_head;

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        pwn_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_index (IDX_W'(k)),
            .i_item  (w_chain[k]),
            .o_item  (w_chain[k+1])
        );
    end

    assign w_last = w_chain[MAX_VERTICES];

    // saturate winding sum to the result range
    assign w_wn_ext = 32'(w_last.wn);

    always_comb begin
        if (w_wn_ext > WIND_LIMIT) begin
            w_wn_sat = WIND_W'(WIND_LIMIT);
        end else if (w_wn_ext < -WIND_LIMIT) begin
            w_wn_sat = WIND_W'(-WIND_LIMIT);
        end else begin
            w_wn_sat = w_wn_ext[WIND_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= (w_last.kind == K_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_inside  <= (w_last.wn != '0);
            r_winding <= w_wn_sat;
            r_ovf_out <= w_last.ovf;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_inside;
    assign o_winding    = r_winding;
    assign o_overflowed = r_ovf_out;

endmodule

>>> rtl/pwn_cell.sv
// one cell of the vertex chain: stores one vertex and scores one edge of a query
// depends on pwn_pkg
`timescale 1ns / 1ps

module pwn_cell import pwn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_index,
    input  t_item            i_item,
    output t_item            o_item
);

    logic signed [COORD_BITS-1:0] r_vx;
    logic signed [COORD_BITS-1:0] r_vy;
    t_item                        r_item;
    t_item                        n_item;

    logic                         w_write;
    logic                         w_edge;
    logic signed [DIFF_W-1:0]     w_dx1;
    logic signed [DIFF_W-1:0]     w_dy1;
    logic signed [DIFF_W-1:0]     w_dxp;
    logic signed [DIFF_W-1:0]     w_dyp;
    logic signed [PROD_W-1:0]     w_m1;
    logic signed [PROD_W-1:0]     w_m2;
    logic signed [CROSS_W-1:0]    w_cross;
    logic                         w_up;
    logic                         w_down;

    // append lands here when its slot matches this cell
    assign w_write = (i_item.kind == K_APPEND) && (i_item.cnt[IDX_W-1:0] == i_index);

    // edge from previous vertex to this one exists inside the polygon length
    assign w_edge = (i_item.kind == K_QUERY) && (i_index != '0)
                  && (CNT_W'(i_index) < i_item.cnt);

    // side test: sign of (b - a) x (p - a)
    assign w_dx1   = DIFF_W'(r_vx) - DIFF_W'(i_item.px);
    assign w_dy1   = DIFF_W'(r_vy) - DIFF_W'(i_item.py);
    assign w_dxp   = DIFF_W'(i_item.x) - DIFF_W'(i_item.px);
    assign w_dyp   = DIFF_W'(i_item.y) - DIFF_W'(i_item.py);
    assign w_m1    = PROD_W'(w_dx1) * PROD_W'(w_dyp);
    assign w_m2    = PROD_W'(w_dxp) * PROD_W'(w_dy1);
    assign w_cross = CROSS_W'(w_m1) - CROSS_W'(w_m2);

    // upward crossing with point left, downward crossing with point right
    assign w_up   = (i_item.py <= i_item.y) && (r_vy > i_item.y) && (w_cross > 0);
    assign w_down = (i_item.py > i_item.y) && (r_vy <= i_item.y) && (w_cross < 0);

    // next word for the neighbour
    always_comb begin
        n_item    = i_item;
        n_item.px = r_vx;
        n_item.py = r_vy;
        if (w_edge && w_up) begin
            n_item.wn = i_item.wn + WN_W'(1);
        end else if (w_edge && w_down) begin
            n_item.wn = i_item.wn - WN_W'(1);
        end
    end

    // stored vertex
    always_ff @(posedge i_clk) begin
        if (i_en && w_write) begin
            r_vx <= i_item.x;
            r_vy <= i_item.y;
        end
    end

    // word register towards the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.kind <= K_NONE;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

>>> rtl/pwn_checker.sv
// port-level checks of the winding-number tester, bound to the top level
// depends on polygon_winding_number_test
`timescale 1ns / 1ps

module pwn_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_stall,
    input  logic [1:0]        i_mode,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    input  logic              o_valid,
    input  logic              i_stall,
    input  logic              o_inside_res,
    input  logic signed [8:0] o_winding,
    input  logic              o_overflowed
);

    // a held result word keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_winding) && $stable(o_inside_res)
                               && $stable(o_overflowed))
        else $error("result word changed while stalled");

    // inside flag agrees with the winding number
    a_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_inside_res == (o_winding != 9'sd0)))
        else $error("inside flag disagrees with winding");

    // input is held off only by a waiting result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // winding stays inside the saturated range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_winding != -9'sd256))
        else $error("winding out of range");

    // no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word after reset");

endmodule

bind polygon_winding_number_test pwn_checker u_pwn_checker (.*);
